// ===== hdl/double_hash_table_engine_macros.svh =====
// assertion helpers for the hash table engine
`ifndef DOUBLE_HASH_TABLE_ENGINE_MACROS_SVH
`define DOUBLE_HASH_TABLE_ENGINE_MACROS_SVH

// property holds at every clock edge outside reset
`define DHT_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dht_pkg.sv =====
package dht_pkg;
	localparam int TABLE_SIZE_DEF    = 8191;
	localparam int MAX_KEY_BYTES_DEF = 8;
	localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
	localparam int          MIX_SHIFT   = 15;
	localparam logic [31:0] SEED1_RESET = 32'h12345678;
	localparam logic [31:0] SEED2_RESET = 32'h87654321;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] SL_EMPTY   = 2'd0;
	localparam logic [1:0] SL_LIVE    = 2'd1;
	localparam logic [1:0] SL_DELETED = 2'd2;

	localparam logic CFG_PRIMARY = 1'b0;
	localparam logic CFG_STEP    = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH_X, S_HASH_M, S_HASH_S, S_ADDR, S_MOD,
		S_READ, S_WAIT, S_EVAL, S_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic hash_xor;
		logic hash_mul;
		logic hash_shift;
		logic addr_calc;
		logic mod_step;
		logic rd;
		logic eval;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic mod_done;
		logic stop;
		logic quick_fail;
	} sts_t;
endpackage

// ===== hdl/dht_if.sv =====
interface dht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] key_bytes;
	logic [3:0]  key_length;
	logic [31:0] value_in;
	modport source (output valid, op, key_bytes, key_length, value_in, input ready);
	modport sink (input valid, op, key_bytes, key_length, value_in, output ready);
endinterface

interface dht_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [12:0] slot_index;
	logic [12:0] entry_count;
	modport source (output valid, status, value_out, slot_index, entry_count, input ready);
	modport sink (input valid, status, value_out, slot_index, entry_count, output ready);
endinterface

interface dht_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/double_hash_table_engine.sv =====
// channel | dir  | beat content
// req     | in   | op, key_bytes, key_length, value_in
// rsp     | out  | status, value_out, slot_index, entry_count
// cfg     | in   | index (0 primary seed, 1 step seed), data
// a request is loaded, hashed byte by byte (xor, multiply, shift), probed, then answered
// a probe is address, reciprocal-multiply mod, store read, wait and evaluate
// after reset a clearing pass sweeps every slot status to empty; no request taken meanwhile
// config writes are taken every cycle; the result holds until its beat is taken
`include "double_hash_table_engine_macros.svh"
module double_hash_table_engine #(
	parameter int TABLE_SIZE    = dht_pkg::TABLE_SIZE_DEF,
	parameter int MAX_KEY_BYTES = dht_pkg::MAX_KEY_BYTES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	dht_req_if.sink  req,
	dht_rsp_if.source rsp,
	dht_cfg_if.sink  cfg
);
	dht_pkg::cmd_t cmd;
	dht_pkg::sts_t sts;
	logic [31:0] seed1_q, seed2_q;

	// seed registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed1_q <= dht_pkg::SEED1_RESET;
			seed2_q <= dht_pkg::SEED2_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == dht_pkg::CFG_PRIMARY) seed1_q <= cfg.data;
			else seed2_q <= cfg.data;
		end
	end

	dht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	dht_datapath #(.TABLE_SIZE(TABLE_SIZE), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.seed1(seed1_q), .seed2(seed2_q),
		.op(req.op), .key_bytes(req.key_bytes), .key_length(req.key_length),
		.value_in(req.value_in),
		.status(rsp.status), .value_out(rsp.value_out),
		.slot_index(rsp.slot_index), .entry_count(rsp.entry_count)
	);

	`DHT_ASSERT_CLK(a_excl, !(req.ready && rsp.valid), "request taken while result pending")
	`DHT_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
	`DHT_ASSERT_NEXT(a_acc, req.valid && req.ready, !rsp.valid, "result too early")
endmodule

// ===== hdl/dht_ctrl.sv =====
module dht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  dht_pkg::sts_t     sts,
	output dht_pkg::cmd_t     cmd
);
	dht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dht_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dht_pkg::S_CLEAR: if (sts.clr_done) state_d = dht_pkg::S_IDLE;
			dht_pkg::S_IDLE: if (req_valid) state_d = dht_pkg::S_HASH_X;
			dht_pkg::S_HASH_X: begin
				if (sts.hash_done) state_d = sts.quick_fail ? dht_pkg::S_DONE : dht_pkg::S_ADDR;
				else state_d = dht_pkg::S_HASH_M;
			end
			dht_pkg::S_HASH_M: state_d = dht_pkg::S_HASH_S;
			dht_pkg::S_HASH_S: state_d = dht_pkg::S_HASH_X;
			dht_pkg::S_ADDR: state_d = dht_pkg::S_MOD;
			dht_pkg::S_MOD: if (sts.mod_done) state_d = dht_pkg::S_READ;
			dht_pkg::S_READ: state_d = dht_pkg::S_WAIT;
			dht_pkg::S_WAIT: state_d = dht_pkg::S_EVAL;
			dht_pkg::S_EVAL: state_d = sts.stop ? dht_pkg::S_DONE : dht_pkg::S_ADDR;
			dht_pkg::S_DONE: if (rsp_ready) state_d = dht_pkg::S_IDLE;
			default: state_d = dht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		case (state_q)
			dht_pkg::S_CLEAR: cmd.clr_step = !sts.clr_done;
			dht_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			dht_pkg::S_HASH_X: cmd.hash_xor = !sts.hash_done;
			dht_pkg::S_HASH_M: cmd.hash_mul = 1'b1;
			dht_pkg::S_HASH_S: cmd.hash_shift = 1'b1;
			dht_pkg::S_ADDR: cmd.addr_calc = 1'b1;
			dht_pkg::S_MOD: cmd.mod_step = 1'b1;
			dht_pkg::S_READ: cmd.rd = 1'b1;
			dht_pkg::S_EVAL: cmd.eval = 1'b1;
			dht_pkg::S_DONE: rsp_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== hdl/dht_datapath.sv =====
`include "double_hash_table_engine_macros.svh"
module dht_datapath #(
	parameter int TABLE_SIZE    = dht_pkg::TABLE_SIZE_DEF,
	parameter int MAX_KEY_BYTES = dht_pkg::MAX_KEY_BYTES_DEF,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dht_pkg::cmd_t     cmd,
	output dht_pkg::sts_t     sts,
	input  logic [31:0]       seed1,
	input  logic [31:0]       seed2,
	input  logic [1:0]        op,
	input  logic [63:0]       key_bytes,
	input  logic [3:0]        key_length,
	input  logic [31:0]       value_in,
	output logic [1:0]        status,
	output logic [31:0]       value_out,
	output logic [12:0]       slot_index,
	output logic [12:0]       entry_count
);
	localparam logic [3:0] MAXL = 4'(MAX_KEY_BYTES);
	localparam logic [AW-1:0] TOP = AW'(TABLE_SIZE - 1);
	localparam logic [16:0] FULL_CNT = 17'(TABLE_SIZE - 1);
	localparam logic [16:0] NPROBE = 17'(TABLE_SIZE);
	// floor(2^32 / size), quotient estimate is at most one short
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SIZE));

	// slot store, separate arrays
	logic [1:0]  stat_mem [TABLE_SIZE];
	logic [63:0] key_mem [TABLE_SIZE];
	logic [3:0]  len_mem [TABLE_SIZE];
	logic [31:0] val_mem [TABLE_SIZE];

	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [3:0]  len_q;
	logic [31:0] val_q;
	logic [31:0] h1_q, h2_q, t_q;
	logic [31:0] p1_q, p2_q;
	logic [3:0]  byte_q;
	logic [16:0] probe_q;
	logic [16:0] live_q;
	logic [AW-1:0] clr_q, pos_q;
	logic [1:0]  mbit_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q;
	logic [1:0]  rd_stat_q;
	logic [63:0] rd_key_q;
	logic [3:0]  rd_len_q;
	logic [31:0] rd_val_q;
	logic [1:0]  status_q;
	logic [31:0] vout_q;
	logic [AW-1:0] sidx_q;
	logic clr_done_q;

	logic [3:0]  len_c;
	logic [63:0] mask_c;
	logic [7:0]  byte_c;
	logic [31:0] m1, m2;

	always_comb begin
		len_c = (key_length > MAXL) ? MAXL : key_length;
		mask_c = (len_c >= 4'd8) ? '1 : ((64'd1 << {len_c[2:0], 3'b000}) - 64'd1);
		byte_c = key_q[{byte_q[2:0], 3'b000} +: 8];
		m1 = p1_q;
		m2 = p2_q;
	end

	logic bad;
	always_comb begin
		bad = (op_q == dht_pkg::OP_INSERT) ? (rd_stat_q != dht_pkg::SL_LIVE)
			: (rd_stat_q == dht_pkg::SL_LIVE && rd_len_q == len_q && rd_key_q == key_q);
		sts.clr_done = clr_done_q;
		sts.hash_done = (byte_q == len_q);
		sts.mod_done = (mbit_q == 2'd0);
		sts.stop = bad || (op_q != dht_pkg::OP_INSERT && rd_stat_q == dht_pkg::SL_EMPTY)
			|| (probe_q == NPROBE - 17'd1);
		sts.quick_fail = !(op_q == dht_pkg::OP_INSERT || op_q == dht_pkg::OP_SEARCH
			|| op_q == dht_pkg::OP_REMOVE)
			|| (op_q == dht_pkg::OP_INSERT && live_q == FULL_CNT);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) stat_mem[clr_q] <= dht_pkg::SL_EMPTY;
		if (cmd.rd) begin
			rd_stat_q <= stat_mem[pos_q];
			rd_key_q  <= key_mem[pos_q];
			rd_len_q  <= len_mem[pos_q];
			rd_val_q  <= val_mem[pos_q];
		end
		if (cmd.eval && bad) begin
			if (op_q == dht_pkg::OP_INSERT) begin
				stat_mem[pos_q] <= dht_pkg::SL_LIVE;
				key_mem[pos_q] <= key_q;
				len_mem[pos_q] <= len_q;
				val_mem[pos_q] <= val_q;
			end else if (op_q == dht_pkg::OP_REMOVE) begin
				stat_mem[pos_q] <= dht_pkg::SL_DELETED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_done_q <= 1'b0;
			live_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == TOP) clr_done_q <= 1'b1;
			end
			if (cmd.eval && bad) begin
				if (op_q == dht_pkg::OP_INSERT) live_q <= live_q + 17'd1;
				else if (op_q == dht_pkg::OP_REMOVE) live_q <= live_q - 17'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			len_q <= len_c;
			key_q <= key_bytes & mask_c;
			val_q <= value_in;
			h1_q <= seed1;
			h2_q <= seed2;
			byte_q <= '0;
			probe_q <= '0;
			// an insert that never finds a free slot reports a full table
			status_q <= (op == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL : dht_pkg::ST_NOTFOUND;
			vout_q <= '0;
			sidx_q <= '0;
		end
		if (cmd.hash_xor) begin
			h1_q <= h1_q ^ {24'd0, byte_c};
			h2_q <= h2_q ^ {24'd0, byte_c};
		end
		if (cmd.hash_mul) begin
			p1_q <= h1_q * dht_pkg::MIX_MULT;
			p2_q <= h2_q * dht_pkg::MIX_MULT;
		end
		if (cmd.hash_shift) begin
			h1_q <= m1 ^ (m1 >> dht_pkg::MIX_SHIFT);
			h2_q <= m2 ^ (m2 >> dht_pkg::MIX_SHIFT);
			byte_q <= byte_q + 4'd1;
		end
		if (cmd.addr_calc) begin
			t_q <= h1_q + 32'(probe_q) * h2_q;
			mbit_q <= 2'd3;
		end
		// mod by reciprocal multiply: estimate, remainder, one correction
		if (cmd.mod_step) begin
			case (mbit_q)
				2'd3: prod_q <= 64'(t_q) * 64'(RECIP);
				2'd2: rem_q <= t_q - prod_q[63:32] * 32'(TABLE_SIZE);
				2'd1: pos_q <= (rem_q >= 32'(TABLE_SIZE)) ? AW'(rem_q - 32'(TABLE_SIZE))
					: AW'(rem_q);
				default: ;
			endcase
			if (mbit_q != 2'd0) mbit_q <= mbit_q - 2'd1;
		end
		if (cmd.eval) begin
			probe_q <= probe_q + 17'd1;
			if (bad) begin
				status_q <= dht_pkg::ST_OK;
				sidx_q <= pos_q;
				if (op_q == dht_pkg::OP_SEARCH) vout_q <= rd_val_q;
			end else if (sts.stop && op_q == dht_pkg::OP_INSERT) begin
				status_q <= dht_pkg::ST_FULL;
			end
		end
	end

	assign status = status_q;
	assign value_out = vout_q;
	assign slot_index = 13'(sidx_q);
	assign entry_count = live_q[12:0];

	`DHT_ASSERT_CLK(a_live_bound, live_q <= FULL_CNT, "live count beyond table capacity")
	`DHT_ASSERT_NEXT(a_clr_once, clr_done_q, clr_done_q, "clear flag dropped")
	`DHT_ASSERT_CLK(a_no_clear_busy, !(cmd.clr_step && cmd.eval), "clear during probe")
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = dht_pkg::TABLE_SIZE_DEF;

	// the op code that the block does not define
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one expected response beat
	typedef struct {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [12:0] slot_index;
		logic [12:0] entry_count;
	} table_answer_t;

	// shadow copy of the hash table, answers every accepted request in order
	class table_scoreboard;
		logic [31:0] seed_home;
		logic [31:0] seed_step;
		logic [1:0]  slot_state [SLOTS];
		logic [63:0] slot_key [SLOTS];
		logic [3:0]  slot_len [SLOTS];
		logic [31:0] slot_value [SLOTS];
		int unsigned live;
		table_answer_t answers[$];
		int unsigned errors;

		function new();
			seed_home = dht_pkg::SEED1_RESET;
			seed_step = dht_pkg::SEED2_RESET;
			foreach (slot_state[i]) slot_state[i] = dht_pkg::SL_EMPTY;
			live = 0;
			errors = 0;
		endfunction

		function void write_seed(logic idx, logic [31:0] data);
			if (idx == dht_pkg::CFG_PRIMARY) seed_home = data;
			else seed_step = data;
		endfunction

		function logic [31:0] mix(logic [63:0] key, int unsigned len, logic [31:0] seed);
			logic [31:0] h;
			h = seed;
			for (int k = 0; k < len; k++) begin
				h ^= {24'd0, key[8*k +: 8]};
				h = h * dht_pkg::MIX_MULT;
				h ^= h >> dht_pkg::MIX_SHIFT;
			end
			return h;
		endfunction

		function void note_request(logic [1:0] op, logic [63:0] key_in, logic [3:0] len_in,
				logic [31:0] value);
			int unsigned len;
			logic [63:0] key;
			logic [31:0] h1, h2, t;
			int unsigned pos;
			table_answer_t a;
			len = (len_in > dht_pkg::MAX_KEY_BYTES_DEF) ? dht_pkg::MAX_KEY_BYTES_DEF : len_in;
			key = (len >= 8) ? key_in : (key_in & ((64'd1 << (8 * len)) - 64'd1));
			h1 = mix(key, len, seed_home);
			h2 = mix(key, len, seed_step);
			a.status = dht_pkg::ST_NOTFOUND;
			a.value_out = '0;
			a.slot_index = '0;
			if (op == dht_pkg::OP_INSERT) begin
				a.status = dht_pkg::ST_FULL;
				if (live != SLOTS - 1) begin
					for (int unsigned i = 0; i < SLOTS; i++) begin
						t = h1 + i * h2;
						pos = t % SLOTS;
						if (slot_state[pos] != dht_pkg::SL_LIVE) begin
							slot_state[pos] = dht_pkg::SL_LIVE;
							slot_key[pos] = key;
							slot_len[pos] = 4'(len);
							slot_value[pos] = value;
							live++;
							a.status = dht_pkg::ST_OK;
							a.slot_index = 13'(pos);
							break;
						end
					end
				end
			end else if (op == dht_pkg::OP_SEARCH || op == dht_pkg::OP_REMOVE) begin
				// tombstones are passed over, an empty slot ends the walk
				for (int unsigned i = 0; i < SLOTS; i++) begin
					t = h1 + i * h2;
					pos = t % SLOTS;
					if (slot_state[pos] == dht_pkg::SL_EMPTY) break;
					if (slot_state[pos] == dht_pkg::SL_LIVE && slot_len[pos] == len
							&& slot_key[pos] == key) begin
						a.status = dht_pkg::ST_OK;
						a.slot_index = 13'(pos);
						if (op == dht_pkg::OP_SEARCH) begin
							a.value_out = slot_value[pos];
						end else begin
							slot_state[pos] = dht_pkg::SL_DELETED;
							live--;
						end
						break;
					end
				end
			end
			a.entry_count = 13'(live);
			answers.push_back(a);
		endfunction

		function void check_result(logic [1:0] status, logic [31:0] value_out,
				logic [12:0] slot_index, logic [12:0] entry_count);
			table_answer_t a;
			if (answers.size() == 0) begin
				$error("response beat with no request outstanding");
				errors++;
				return;
			end
			a = answers.pop_front();
			if (status !== a.status) begin
				$error("status: expected %0d, got %0d", a.status, status);
				errors++;
			end
			if (value_out !== a.value_out) begin
				$error("value_out: expected %h, got %h", a.value_out, value_out);
				errors++;
			end
			if (slot_index !== a.slot_index) begin
				$error("slot_index: expected %0d, got %0d", a.slot_index, slot_index);
				errors++;
			end
			if (entry_count !== a.entry_count) begin
				$error("entry_count: expected %0d, got %0d", a.entry_count, entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dht_req_if req();
	dht_rsp_if rsp();
	dht_cfg_if cfg();

	double_hash_table_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	table_scoreboard sb;

	// pool of keys already used, so searches and removes actually hit
	logic [63:0] key_pool[$];
	int unsigned len_pool[$];

	// when set, neither side inserts gaps
	bit steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 200);
	endfunction

	// one request beat; valid stays high across back-to-back beats
	task automatic send_request(logic [1:0] op, logic [63:0] key, logic [3:0] len,
			logic [31:0] value);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.op = op;
		req.key_bytes = key;
		req.key_length = len;
		req.value_in = value;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, key, len, value);
		@(negedge clk);
	endtask

	// hold off until every response is back
	task automatic drain();
		req.valid = 1'b0;
		while (sb.answers.size() != 0) @(negedge clk);
		// each request answers, so the block is idle right away; the wait below is only a margin
		repeat (5) @(negedge clk);
	endtask

	task automatic write_seed(logic idx, logic [31:0] data);
		drain();
		cfg.index = idx;
		cfg.data = data;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		sb.write_seed(idx, data);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// noise above the used length must not matter
	function automatic logic [63:0] dirty_key(logic [63:0] key, int unsigned len);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		if (len >= 8) return key;
		return (key & ((64'd1 << (8 * len)) - 64'd1)) | (junk & ~((64'd1 << (8 * len)) - 64'd1));
	endfunction

	function automatic logic [3:0] length_for(int unsigned len);
		// full-length keys may also be sent with an oversized length
		if (len == 8 && $urandom_range(0, 1)) return 4'($urandom_range(9, 15));
		return 4'(len);
	endfunction

	task automatic random_phase(int unsigned count);
		int unsigned r, p, len;
		logic [63:0] key;
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			// a gap-free stretch now and then
			if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
			if (r < 5) begin
				send_request(OP_UNUSED, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
					$urandom);
				continue;
			end
			if (r < 10) begin
				send_request(2'($urandom_range(0, 3)), {$urandom, $urandom},
					4'($urandom_range(0, 15)), $urandom);
				continue;
			end
			op = (r < 50) ? dht_pkg::OP_INSERT : (r < 78) ? dht_pkg::OP_SEARCH
				: dht_pkg::OP_REMOVE;
			if (key_pool.size() != 0
					&& $urandom_range(0, 9) < ((op == dht_pkg::OP_INSERT) ? 3 : 8)) begin
				p = $urandom_range(0, key_pool.size() - 1);
				key = key_pool[p];
				len = len_pool[p];
			end else begin
				len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
				key = {$urandom, $urandom};
				if ($urandom_range(0, 3) == 0) key = key & 64'h0000_00ff_00ff_00ff;
				if (op == dht_pkg::OP_INSERT && key_pool.size() < 64) begin
					key_pool.push_back(key);
					len_pool.push_back(len);
				end else if (op == dht_pkg::OP_INSERT) begin
					p = $urandom_range(0, 63);
					key_pool[p] = key;
					len_pool[p] = len;
				end
			end
			send_request(op, dirty_key(key, len), length_for(len), $urandom);
		end
		steady = 1'b0;
	endtask

	// response side: ready drops for random stretches
	initial begin
		int unsigned hold;
		rsp.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.status, rsp.value_out, rsp.slot_index, rsp.entry_count);
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				rsp.ready = 1'b0;
			end else begin
				hold = pick_gap();
				rsp.ready = (hold == 0);
			end
		end
	end

	initial begin
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = dht_pkg::OP_INSERT;
		req.key_bytes = '0;
		req.key_length = '0;
		req.value_in = '0;
		cfg.valid = 1'b0;
		cfg.index = dht_pkg::CFG_PRIMARY;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty key, zero byte, extremes, oversized length, tombstones, unused op
		send_request(dht_pkg::OP_INSERT, 64'hdead_beef_0000_0000, 4'd0, 32'h0000_0000);
		send_request(dht_pkg::OP_SEARCH, 64'h1234, 4'd0, 32'h0);
		send_request(dht_pkg::OP_INSERT, 64'hffff_ffff_ffff_ff00, 4'd1, 32'hffff_ffff);
		send_request(dht_pkg::OP_SEARCH, 64'h0, 4'd1, 32'h0);
		send_request(dht_pkg::OP_INSERT, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h1111_2222);
		send_request(dht_pkg::OP_SEARCH, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h0);
		send_request(dht_pkg::OP_INSERT, 64'h0000_0000_0063_6261, 4'd3, 32'h5555_aaaa);
		send_request(dht_pkg::OP_SEARCH, 64'hfeed_face_0063_6261, 4'd3, 32'h0);
		send_request(dht_pkg::OP_SEARCH, 64'h0000_0000_0063_6261, 4'd4, 32'h0);
		send_request(dht_pkg::OP_INSERT, 64'h0000_0000_0063_6261, 4'd3, 32'h0bad_0bad);
		send_request(dht_pkg::OP_REMOVE, 64'h0000_0000_0063_6261, 4'd3, 32'h0);
		send_request(dht_pkg::OP_SEARCH, 64'h0000_0000_0063_6261, 4'd3, 32'h0);
		send_request(dht_pkg::OP_REMOVE, 64'h0000_0000_0063_6261, 4'd3, 32'h0);
		send_request(dht_pkg::OP_REMOVE, 64'h0000_0000_0063_6261, 4'd3, 32'h0);
		send_request(dht_pkg::OP_INSERT, 64'h0000_0000_0063_6261, 4'd3, 32'h7777_0000);
		send_request(dht_pkg::OP_SEARCH, 64'h0000_0000_0063_6261, 4'd3, 32'h0);
		send_request(OP_UNUSED, 64'hffff_ffff_ffff_ffff, 4'd15, 32'hffff_ffff);
		send_request(dht_pkg::OP_REMOVE, 64'h0, 4'd0, 32'h0);
		send_request(dht_pkg::OP_SEARCH, 64'h0, 4'd0, 32'h0);
		send_request(dht_pkg::OP_REMOVE, 64'h0123_4567_89ab_cdef, 4'd8, 32'h0);

		random_phase(380);
		write_seed(dht_pkg::CFG_PRIMARY, 32'h0000_0000);
		write_seed(dht_pkg::CFG_STEP, 32'h0000_0000);
		random_phase(380);
		write_seed(dht_pkg::CFG_PRIMARY, 32'hffff_ffff);
		write_seed(dht_pkg::CFG_STEP, 32'hffff_ffff);
		random_phase(380);
		write_seed(dht_pkg::CFG_PRIMARY, $urandom);
		write_seed(dht_pkg::CFG_STEP, $urandom);
		random_phase(380);
		write_seed(dht_pkg::CFG_STEP, 32'h0000_0001);
		random_phase(380);

		// let everything drain, then a little extra
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.answers.size() == 0) begin
			$display("[double_hash_table_engine] OK");
		end else begin
			$display("[double_hash_table_engine] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("[double_hash_table_engine] ERROR");
		$finish;
	end
endmodule
